// ===== rtl/cwbi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cwbi_pkg;

	// Sequencer phases, as reported on the phase output.
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_WAITKEY  = 3'd1,
		PH_START    = 3'd2,
		PH_MARK     = 3'd3,
		PH_MARKHOLD = 3'd4,
		PH_SPACE    = 3'd5,
		PH_HANG     = 3'd6,
		PH_HANGPOLL = 3'd7
	} phase_t;

	// The five radio control lines driven by the sequencer.
	typedef struct packed {
		logic amp;
		logic tx_relay;
		logic iq;
		logic rx_audio;
		logic band_tx;
	} lines_t;

	// Single-bit fields of one poll tick.
	typedef struct packed {
		logic key_a_n;
		logic key_b_n;
		logic tx_lockout;
		logic cw_selected;
		logic synth_ok;
		logic hold_expired;
	} poll_flags_t;

	// Receive state of the lines after reset: amplifier off, relay in receive,
	// I/Q and audio on.
	localparam lines_t LINES_RESET = '{
		amp: 1'b0, tx_relay: 1'b0, iq: 1'b1, rx_audio: 1'b1, band_tx: 1'b0
	};

	// Configuration register file.
	localparam int PITCH_BITS = 14;
	localparam logic [PITCH_BITS-1:0] PITCH_RESET = 14'd700;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_PITCH = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/cwbi_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One poll tick toward the sequencer.
interface cwbi_poll_if #(
	parameter int FREQ_BITS = 28
);
	logic                 valid;
	logic                 ready;
	logic                 key_a_n;
	logic                 key_b_n;
	logic                 tx_lockout;
	logic                 cw_selected;
	logic [FREQ_BITS-1:0] lo_freq;
	logic                 synth_ok;
	logic                 hold_expired;

	modport source (
		output valid, key_a_n, key_b_n, tx_lockout, cw_selected, lo_freq, synth_ok,
			hold_expired,
		input  ready
	);
	modport sink (
		input  valid, key_a_n, key_b_n, tx_lockout, cw_selected, lo_freq, synth_ok,
			hold_expired,
		output ready
	);
endinterface

// One set of control outputs from the sequencer.
interface cwbi_ctrl_if #(
	parameter int FREQ_BITS = 28
);
	logic                 valid;
	logic                 ready;
	logic                 synth_load;
	logic [FREQ_BITS-1:0] synth_freq;
	logic                 amp_on;
	logic                 tx_relay_on;
	logic                 iq_on;
	logic                 rx_audio_on;
	logic                 band_tx;
	logic                 key_down;
	logic                 hold_restart;
	logic [2:0]           phase;

	modport source (
		output valid, synth_load, synth_freq, amp_on, tx_relay_on, iq_on, rx_audio_on,
			band_tx, key_down, hold_restart, phase,
		input  ready
	);
	modport sink (
		input  valid, synth_load, synth_freq, amp_on, tx_relay_on, iq_on, rx_audio_on,
			band_tx, key_down, hold_restart, phase,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/cwbi_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cwbi_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cwbi_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [cwbi_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [cwbi_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                     pready,
	output logic      [cwbi_pkg::PITCH_BITS-1:0]     pitch
);

	logic [cwbi_pkg::PITCH_BITS-1:0]   pitch_q;
	logic [cwbi_pkg::REG_IDX_BITS-1:0] reg_idx;
	logic                              wr_en;

	// Registers sit on 32-bit words; the low address bits are ignored.
	assign reg_idx = paddr[cwbi_pkg::APB_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Pitch register, written in the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= cwbi_pkg::PITCH_RESET;
		end else if (wr_en && (reg_idx == cwbi_pkg::REG_PITCH)) begin
			pitch_q <= pwdata[cwbi_pkg::PITCH_BITS-1:0];
		end
	end

	// Read back, zero-extended; unmapped words read as zero.
	always_comb begin
		prdata = '0;
		if (reg_idx == cwbi_pkg::REG_PITCH) begin
			prdata[cwbi_pkg::PITCH_BITS-1:0] = pitch_q;
		end
	end

	assign pitch = pitch_q;

endmodule

`default_nettype wire

// ===== rtl/cwbi_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cwbi_step #(
	parameter int FREQ_BITS = 28
) (
	input  wire cwbi_pkg::poll_flags_t          flags,
	input  wire logic [FREQ_BITS-1:0]           lo_freq,
	input  wire logic [cwbi_pkg::PITCH_BITS-1:0] pitch,
	input  wire cwbi_pkg::phase_t               phase_cur,
	input  wire logic [FREQ_BITS-1:0]           last_cur,
	input  wire logic                           hold_cur,
	input  wire cwbi_pkg::lines_t               lines_cur,
	input  wire logic                           session_cur,
	output cwbi_pkg::phase_t                    phase_nxt,
	output logic      [FREQ_BITS-1:0]           last_nxt,
	output logic                                hold_nxt,
	output cwbi_pkg::lines_t                    lines_nxt,
	output logic                                session_nxt,
	output logic                                synth_load,
	output logic      [FREQ_BITS-1:0]           synth_freq,
	output logic                                hold_restart
);

	logic                 pressed;
	logic                 hold_pre;
	logic                 may_start;
	logic [FREQ_BITS:0]   tx_sum;
	logic [FREQ_BITS-1:0] tx_freq;

	// Either paddle contact closed counts as a key press.
	assign pressed   = !flags.key_a_n || !flags.key_b_n;
	assign hold_pre  = flags.hold_expired ? 1'b0 : hold_cur;
	assign may_start = !flags.tx_lockout && flags.cw_selected;

	// Transmit frequency: LO plus pitch, saturated at the top of the range.
	assign tx_sum  = {1'b0, lo_freq} + {{(FREQ_BITS + 1 - cwbi_pkg::PITCH_BITS){1'b0}}, pitch};
	assign tx_freq = tx_sum[FREQ_BITS] ? {FREQ_BITS{1'b1}} : tx_sum[FREQ_BITS-1:0];

	// Phase transitions and line updates for one poll tick.
	always_comb begin
		phase_nxt    = phase_cur;
		last_nxt     = last_cur;
		hold_nxt     = hold_pre;
		lines_nxt    = lines_cur;
		session_nxt  = session_cur;
		synth_load   = 1'b0;
		synth_freq   = '0;
		hold_restart = 1'b0;
		case (phase_cur)
			cwbi_pkg::PH_IDLE: begin
				// Retune to LO when it moved; a failed load holds the phase.
				if (last_cur != lo_freq) begin
					synth_load = 1'b1;
					synth_freq = lo_freq;
					if (flags.synth_ok) begin
						last_nxt = lo_freq;
						if (may_start) begin
							phase_nxt = cwbi_pkg::PH_WAITKEY;
						end
					end
				end else if (may_start) begin
					phase_nxt = cwbi_pkg::PH_WAITKEY;
				end
			end
			cwbi_pkg::PH_WAITKEY: begin
				if (pressed) begin
					session_nxt = 1'b1;
					phase_nxt   = cwbi_pkg::PH_START;
				end else begin
					phase_nxt = cwbi_pkg::PH_IDLE;
				end
			end
			cwbi_pkg::PH_START: begin
				lines_nxt.rx_audio = 1'b0;
				lines_nxt.iq       = 1'b0;
				synth_load         = 1'b1;
				synth_freq         = tx_freq;
				if (flags.synth_ok) begin
					phase_nxt = cwbi_pkg::PH_MARK;
				end
			end
			cwbi_pkg::PH_MARK: begin
				lines_nxt.amp      = 1'b1;
				lines_nxt.tx_relay = 1'b1;
				lines_nxt.iq       = 1'b1;
				lines_nxt.band_tx  = 1'b1;
				hold_nxt           = 1'b1;
				phase_nxt          = cwbi_pkg::PH_MARKHOLD;
			end
			cwbi_pkg::PH_MARKHOLD: begin
				if (!pressed) begin
					phase_nxt = cwbi_pkg::PH_SPACE;
				end
			end
			cwbi_pkg::PH_SPACE: begin
				lines_nxt.iq = 1'b0;
				hold_nxt     = 1'b1;
				hold_restart = 1'b1;
				phase_nxt    = cwbi_pkg::PH_HANG;
			end
			cwbi_pkg::PH_HANG: begin
				// Hang time over: retune to LO and restore receive on success.
				if (!hold_pre) begin
					synth_load = 1'b1;
					synth_freq = lo_freq;
					if (flags.synth_ok) begin
						lines_nxt   = cwbi_pkg::LINES_RESET;
						session_nxt = 1'b0;
						phase_nxt   = cwbi_pkg::PH_IDLE;
					end
				end else begin
					phase_nxt = cwbi_pkg::PH_HANGPOLL;
				end
			end
			cwbi_pkg::PH_HANGPOLL: begin
				phase_nxt = pressed ? cwbi_pkg::PH_MARK : cwbi_pkg::PH_HANG;
			end
			default: begin
				phase_nxt = cwbi_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/cw_break_in_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Handshake      Payload
// poll      sink    valid/ready    keys, inhibit, CW mode, LO, synth_ok, hold_expired
// ctrl      source  valid/ready    synth load/frequency, five lines, key_down, restart, phase
// APB       slave   psel/penable   pitch_offset at byte address 0
//
// One poll tick per clock while ctrl does not stall: a transaction is registered,
// stepped through the sequencer from the input register and lands in the output
// register; the sequencer state loop sets the rate.
// Reset puts the sequencer in idle with receive lines restored and pitch 700.
// A stalled output register holds its transaction and stops the input stage;
// poll stays ready while the input stage can move on.

module cw_break_in_sequencer #(
	parameter int FREQ_BITS = 28
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	cwbi_poll_if.sink                                poll,
	cwbi_ctrl_if.source                              ctrl,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cwbi_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [cwbi_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [cwbi_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                     pready
);

	logic [cwbi_pkg::PITCH_BITS-1:0] pitch;

	// Input stage.
	logic                  valid_s1;
	cwbi_pkg::poll_flags_t flags_s1;
	logic [FREQ_BITS-1:0]  lo_freq_s1;

	// Sequencer state.
	cwbi_pkg::phase_t      phase_q;
	logic [FREQ_BITS-1:0]  last_freq_q;
	logic                  hold_q;
	cwbi_pkg::lines_t      lines_q;
	logic                  session_q;

	// Next state and results from the step logic.
	cwbi_pkg::phase_t      phase_nxt;
	logic [FREQ_BITS-1:0]  last_nxt;
	logic                  hold_nxt;
	cwbi_pkg::lines_t      lines_nxt;
	logic                  session_nxt;
	logic                  load_nxt;
	logic [FREQ_BITS-1:0]  freq_nxt;
	logic                  restart_nxt;

	// Output stage.
	logic                  valid_s2;
	logic                  load_s2;
	logic [FREQ_BITS-1:0]  freq_s2;
	cwbi_pkg::lines_t      lines_s2;
	logic                  session_s2;
	logic                  restart_s2;
	cwbi_pkg::phase_t      phase_s2;

	logic                  advance_s1;

	cwbi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pitch   (pitch)
	);

	cwbi_step #(
		.FREQ_BITS (FREQ_BITS)
	) u_step (
		.flags        (flags_s1),
		.lo_freq      (lo_freq_s1),
		.pitch        (pitch),
		.phase_cur    (phase_q),
		.last_cur     (last_freq_q),
		.hold_cur     (hold_q),
		.lines_cur    (lines_q),
		.session_cur  (session_q),
		.phase_nxt    (phase_nxt),
		.last_nxt     (last_nxt),
		.hold_nxt     (hold_nxt),
		.lines_nxt    (lines_nxt),
		.session_nxt  (session_nxt),
		.synth_load   (load_nxt),
		.synth_freq   (freq_nxt),
		.hold_restart (restart_nxt)
	);

	// The registered tick moves on when the output register is free or draining.
	assign advance_s1 = valid_s1 && (!valid_s2 || ctrl.ready);
	assign poll.ready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			flags_s1   <= '{
				key_a_n:      poll.key_a_n,
				key_b_n:      poll.key_b_n,
				tx_lockout:   poll.tx_lockout,
				cw_selected:  poll.cw_selected,
				synth_ok:     poll.synth_ok,
				hold_expired: poll.hold_expired
			};
			lo_freq_s1 <= poll.lo_freq;
		end
	end

	// Sequencer state commits once per stepped transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cwbi_pkg::PH_IDLE;
			last_freq_q <= '0;
			hold_q      <= 1'b0;
			lines_q     <= cwbi_pkg::LINES_RESET;
			session_q   <= 1'b0;
		end else if (advance_s1) begin
			phase_q     <= phase_nxt;
			last_freq_q <= last_nxt;
			hold_q      <= hold_nxt;
			lines_q     <= lines_nxt;
			session_q   <= session_nxt;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (ctrl.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			load_s2    <= load_nxt;
			freq_s2    <= freq_nxt;
			lines_s2   <= lines_nxt;
			session_s2 <= session_nxt;
			restart_s2 <= restart_nxt;
			phase_s2   <= phase_nxt;
		end
	end

	assign ctrl.valid        = valid_s2;
	assign ctrl.synth_load   = load_s2;
	assign ctrl.synth_freq   = freq_s2;
	assign ctrl.amp_on       = lines_s2.amp;
	assign ctrl.tx_relay_on  = lines_s2.tx_relay;
	assign ctrl.iq_on        = lines_s2.iq;
	assign ctrl.rx_audio_on  = lines_s2.rx_audio;
	assign ctrl.band_tx      = lines_s2.band_tx;
	assign ctrl.key_down     = session_s2;
	assign ctrl.hold_restart = restart_s2;
	assign ctrl.phase        = phase_s2;

endmodule

`default_nettype wire
